[sv/fsn_pkg.sv]
// ============================================================================
// fsn_pkg: shared definitions for the swept-tone FM oscillator
// Register indexes, the sequencer state type, the sine lookup result type and
// the elaboration-time quarter-wave sine table generator.
// ============================================================================
package fsn_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTER    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVIATION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE  = 3'd4;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // Sine lookup result: magnitude in Q15 plus a sign flag.
    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } t_sine;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_LFO_SIN = 7'b0000010,
        S_CARR    = 7'b0000100,
        S_CAR_SIN = 7'b0001000,
        S_AMP     = 7'b0010000,
        S_SPAN    = 7'b0100000,
        S_RATE    = 7'b1000000
    } t_state;

    // Q15 magnitude of sin(2*pi*k/2^tbits) for k in the first quarter turn,
    // evaluated as a truncating Taylor series in Q30 through x^13.
    function automatic logic [14:0] quarter_sine(input logic [31:0] k, input int tbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = ({32'd0, k} * TWO_PI_Q30) >> tbits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

[sv/fsn_sine_rom.sv]
// ============================================================================
// fsn_sine_rom: quarter-wave sine lookup with registered read
// Folds a full-turn table index onto a quarter table built at elaboration and
// returns magnitude and sign from a register, in the cycle after the index is presented.
// ============================================================================
module fsn_sine_rom #(
    parameter int TABLE_BITS = fsn_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [TABLE_BITS-1:0] i_index,
    output fsn_pkg::t_sine        o_sine
);

    localparam int QUARTER = 1 << (TABLE_BITS - 2);
    localparam int QDEPTH  = QUARTER + 1;
    localparam int ADDR_W  = TABLE_BITS - 1;

    typedef logic [14:0] t_qtab [QDEPTH];

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int k = 0; k < QDEPTH; k++) begin
            tab[k] = fsn_pkg::quarter_sine(32'(k), TABLE_BITS);
        end
        return tab;
    endfunction

    localparam t_qtab C_QTAB = build_qtab();

    logic [1:0]        quad;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] addr;
    logic [14:0]       r_mag;
    logic              r_neg;

    assign quad   = i_index[TABLE_BITS-1 -: 2];
    assign offset = {1'b0, i_index[TABLE_BITS-3:0]};
    // Odd quadrants run the quarter table backwards.
    assign addr   = quad[0] ? (ADDR_W'(QUARTER) - offset) : offset;

    always_ff @(posedge i_clk) begin
        r_mag <= C_QTAB[addr];
        r_neg <= quad[1];
    end

    assign o_sine.neg = r_neg;
    assign o_sine.mag = r_mag;

endmodule

[sv/fm_swept_tone_nco.sv]
// ============================================================================
// fm_swept_tone_nco: FM tone generator with a randomly re-timed sine LFO
// One request is one sample tick; each yields one signed 16-bit PCM sample.
// A small sequencer shares one 33x33 signed multiplier and one sine ROM.
// ============================================================================
//
//  Channel   Direction  Handshake                  Payload
//  -------   ---------  -------------------------  ------------------------------------
//  in        sink       i_in_valid / o_in_ready    i_random_word, i_last_in_frame
//  out       source     o_out_valid / i_out_ready  o_sample, o_rate_changed, o_frame_end
//  cfg       sink       i_cfg_wr_en (no wait)      i_cfg_index, i_cfg_data
//
//  Once a request is accepted, ready stays low while the sequencer runs through
//  S_LFO_SIN, S_CARR, S_CAR_SIN, S_AMP, S_SPAN and S_RATE. The sequence is set
//  by three passes through the shared multiplier and two registered sine
//  ROM reads, each followed by a dependent step.
//  The finished sample sits in an output register, so the block goes back to
//  idle while it waits; only if the previous sample is still untaken when the
//  next one finishes does the sequencer hold in its last state.
//  Reset is synchronous and active low; it clears phases, the LFO increment and
//  all configuration registers. No clearing pass is needed.
//
module fm_swept_tone_nco #(
    parameter int SINE_TABLE_BITS = fsn_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [31:0]                     i_random_word,
    input  logic                            i_last_in_frame,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [15:0]              o_sample,
    output logic                            o_rate_changed,
    output logic                            o_frame_end,
    // Configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [fsn_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [fsn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [30:0] r_center;
    logic [30:0] r_deviation;
    logic [14:0] r_peak;
    logic [31:0] r_min_rate;
    logic [31:0] r_max_rate;

    // Oscillator state.
    logic [31:0] r_carrier_phase;
    logic [31:0] r_lfo_phase;
    logic [31:0] r_lfo_inc;

    // Per-request working registers.
    fsn_pkg::t_state     r_state;
    fsn_pkg::t_state     n_state;
    logic [31:0]         r_rand;
    logic                r_last;
    logic                r_wrap;
    logic [31:0]         r_span;
    logic                r_car_neg;
    logic signed [15:0]  r_sample;
    logic signed [65:0]  r_prod;

    // Output register.
    logic                r_out_valid;
    logic signed [15:0]  r_out_sample;
    logic                r_out_changed;
    logic                r_out_frame_end;

    logic                     in_accept;
    logic                     out_free;
    logic                     finish;
    logic [SINE_TABLE_BITS-1:0] rom_index;
    fsn_pkg::t_sine           rom_sine;
    logic signed [32:0]       sine_signed;
    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_p;
    logic [15:0]              mag_ext;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign finish    = (r_state == fsn_pkg::S_RATE) && out_free;

    // The ROM sees the LFO phase except while the fresh carrier phase is looked up.
    assign rom_index = (r_state == fsn_pkg::S_CAR_SIN)
                     ? r_carrier_phase[31 -: SINE_TABLE_BITS]
                     : r_lfo_phase[31 -: SINE_TABLE_BITS];

    fsn_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk   (i_clk),
        .i_index (rom_index),
        .o_sine  (rom_sine)
    );

    always_comb begin
        sine_signed = $signed({18'd0, rom_sine.mag});
        if (rom_sine.neg) begin
            sine_signed = -sine_signed;
        end
    end

    // Shared multiplier operand selection. The product is registered before use.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            fsn_pkg::S_LFO_SIN: begin
                // Deviation times signed LFO sine.
                mul_a = $signed({2'b00, r_deviation});
                mul_b = sine_signed;
            end
            fsn_pkg::S_AMP: begin
                // Peak times carrier sine magnitude; sign is applied afterwards so
                // the result truncates toward zero.
                mul_a = $signed({18'd0, r_peak});
                mul_b = $signed({18'd0, rom_sine.mag});
            end
            fsn_pkg::S_SPAN: begin
                // Random word times rate span; the top word scales the span.
                mul_a = $signed({1'b0, r_rand});
                mul_b = $signed({1'b0, r_span});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fsn_pkg::S_IDLE:    if (in_accept) n_state = fsn_pkg::S_LFO_SIN;
            fsn_pkg::S_LFO_SIN: n_state = fsn_pkg::S_CARR;
            fsn_pkg::S_CARR:    n_state = fsn_pkg::S_CAR_SIN;
            fsn_pkg::S_CAR_SIN: n_state = fsn_pkg::S_AMP;
            fsn_pkg::S_AMP:     n_state = fsn_pkg::S_SPAN;
            fsn_pkg::S_SPAN:    n_state = fsn_pkg::S_RATE;
            fsn_pkg::S_RATE:    if (out_free) n_state = fsn_pkg::S_IDLE;
            default:            n_state = fsn_pkg::S_IDLE;
        endcase
    end

    assign mag_ext = {1'b0, r_prod[29:15]};

    // Control state, configuration and oscillator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= fsn_pkg::S_IDLE;
            r_center        <= '0;
            r_deviation     <= '0;
            r_peak          <= '0;
            r_min_rate      <= '0;
            r_max_rate      <= '0;
            r_carrier_phase <= '0;
            r_lfo_phase     <= '0;
            r_lfo_inc       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    fsn_pkg::REG_CENTER:    r_center    <= i_cfg_data[30:0];
                    fsn_pkg::REG_DEVIATION: r_deviation <= i_cfg_data[30:0];
                    fsn_pkg::REG_PEAK:      r_peak      <= i_cfg_data[14:0];
                    fsn_pkg::REG_MIN_RATE:  r_min_rate  <= i_cfg_data;
                    fsn_pkg::REG_MAX_RATE:  r_max_rate  <= i_cfg_data;
                    default: ;
                endcase
            end

            // Carrier advances by center plus the floored deviation term.
            if (r_state == fsn_pkg::S_CARR) begin
                r_carrier_phase <= r_carrier_phase + {1'b0, r_center} + r_prod[46:15];
            end

            if (r_state == fsn_pkg::S_AMP) begin
                {r_wrap, r_lfo_phase} <= {1'b0, r_lfo_phase} + {1'b0, r_lfo_inc};
            end

            // A new LFO rate is drawn only on a wrap. Writing the minimum rate
            // also loads it at once as the LFO increment; the phase runs on.
            if (i_cfg_wr_en && (i_cfg_index == fsn_pkg::REG_MIN_RATE)) begin
                r_lfo_inc <= i_cfg_data;
            end else if (finish && r_wrap) begin
                r_lfo_inc <= r_min_rate + r_prod[63:32];
            end

            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rand <= i_random_word;
            r_last <= i_last_in_frame;
        end
        if ((r_state == fsn_pkg::S_LFO_SIN) || (r_state == fsn_pkg::S_AMP) ||
            (r_state == fsn_pkg::S_SPAN)) begin
            r_prod <= mul_p;
        end
        if (r_state == fsn_pkg::S_AMP) begin
            r_car_neg <= rom_sine.neg;
            r_span    <= (r_max_rate > r_min_rate) ? (r_max_rate - r_min_rate) : '0;
        end
        if (r_state == fsn_pkg::S_SPAN) begin
            r_sample <= r_car_neg ? $signed(-mag_ext) : $signed(mag_ext);
        end
        if (finish) begin
            r_out_sample    <= r_sample;
            r_out_changed   <= r_wrap;
            r_out_frame_end <= r_last;
        end
    end

    assign o_in_ready     = (r_state == fsn_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample       = r_out_sample;
    assign o_rate_changed = r_out_changed;
    assign o_frame_end    = r_out_frame_end;

    // A request keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("block still ready right after accepting a request");

    // Finishing a request always presents a result and returns to idle.
    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (o_out_valid && (r_state == fsn_pkg::S_IDLE)))
        else $error("finished request did not produce a result");

    // A rate change is flagged only when the LFO wrapped.
    a_changed_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (finish && !r_wrap) |=> !o_rate_changed)
        else $error("rate change flagged without an LFO wrap");

endmodule
